FILE: rtl/ptc_pkg.sv
// Shared types, constants and the face table of the tetrahedron classifier.
package ptc_pkg;

    localparam int COORD_BITS_DEF = 20;
    localparam int FIELD_BITS     = 60;
    localparam int IN_FIELDS      = 5;
    localparam int IN_DATA_BITS   = 304;
    localparam int OUT_DATA_BITS  = 16;

    localparam logic [2:0] KIND_OUTSIDE = 3'd0;
    localparam logic [2:0] KIND_VERTEX  = 3'd1;
    localparam logic [2:0] KIND_EDGE    = 3'd2;
    localparam logic [2:0] KIND_FACE    = 3'd3;
    localparam logic [2:0] KIND_CELL    = 3'd4;

    typedef struct packed {
        logic       hit;
        logic [1:0] idx;
    } hit_t;

    typedef struct packed {
        logic neg;
        logic zero;
    } sign_t;

    // Vertex j of face i, the faces wound so that an inside point sees them positive
    function automatic logic [1:0] face_vtx(input logic [1:0] face, input logic [1:0] j);
        logic [1:0] v;
        v = 2'd0;
        unique case (face)
            2'd0: v = (j == 2'd0) ? 2'd0 : (j == 2'd1) ? 2'd1 : 2'd2;
            2'd1: v = (j == 2'd0) ? 2'd0 : (j == 2'd1) ? 2'd2 : 2'd3;
            2'd2: v = (j == 2'd0) ? 2'd0 : (j == 2'd1) ? 2'd3 : 2'd1;
            2'd3: v = (j == 2'd0) ? 2'd1 : (j == 2'd1) ? 2'd3 : 2'd2;
            default: v = 2'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/ptc_front.sv
// Input stage: unpack coordinates, form edge vectors per face, match the query to a corner.
module ptc_front #(
    parameter int COORD_BITS = ptc_pkg::COORD_BITS_DEF,
    localparam int D = COORD_BITS + 1
) (
    input  logic                                                   clk,
    input  logic                                                   en,
    input  logic [ptc_pkg::IN_FIELDS-1:0][ptc_pkg::FIELD_BITS-1:0] pts,
    output logic [3:0][2:0][D-1:0]                                 u_reg,
    output logic [3:0][2:0][D-1:0]                                 v_reg,
    output logic [3:0][2:0][D-1:0]                                 w_reg,
    output ptc_pkg::hit_t                                          hit_reg
);

    logic [ptc_pkg::IN_FIELDS-1:0][2:0][D-1:0] crd;
    logic [3:0][2:0][D-1:0]                    u_next;
    logic [3:0][2:0][D-1:0]                    v_next;
    logic [3:0][2:0][D-1:0]                    w_next;
    ptc_pkg::hit_t                             hit_next;

    always_comb
    begin
        for (int p = 0; p < ptc_pkg::IN_FIELDS; p++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                crd[p][k] = {pts[p][k*COORD_BITS + COORD_BITS - 1],
                             pts[p][k*COORD_BITS +: COORD_BITS]};
            end
        end
    end

    always_comb
    begin
        logic [1:0] a;
        logic [1:0] b;
        logic [1:0] c;
        for (int i = 0; i < 4; i++)
        begin
            a = ptc_pkg::face_vtx(2'(i), 2'd0);
            b = ptc_pkg::face_vtx(2'(i), 2'd1);
            c = ptc_pkg::face_vtx(2'(i), 2'd2);
            for (int k = 0; k < 3; k++)
            begin
                // differences of two COORD_BITS values always fit in D bits
                u_next[i][k] = crd[b][k] - crd[a][k];
                v_next[i][k] = crd[c][k] - crd[a][k];
                w_next[i][k] = crd[4][k] - crd[a][k];
            end
        end
    end

    // lowest matching corner wins
    always_comb
    begin
        hit_next = '0;
        for (int i = 3; i >= 0; i--)
        begin
            if (crd[i] == crd[4])
            begin
                hit_next.hit = 1'b1;
                hit_next.idx = 2'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg   <= u_next;
            v_reg   <= v_next;
            w_reg   <= w_next;
            hit_reg <= hit_next;
        end
    end

endmodule

FILE: rtl/ptc_orient.sv
// Exact orientation sign of one face: five register stages over a 3x3 determinant.
module ptc_orient #(
    parameter int COORD_BITS = ptc_pkg::COORD_BITS_DEF,
    localparam int D = COORD_BITS + 1
) (
    input  logic                clk,
    input  logic                en,
    input  logic [2:0][D-1:0]   u,
    input  logic [2:0][D-1:0]   v,
    input  logic [2:0][D-1:0]   w,
    output ptc_pkg::sign_t      sgn_reg
);

    localparam int PW = 2 * D;          // one 2x2 product
    localparam int CW = 2 * D + 1;      // cross product term
    localparam int L  = D + 1;          // low split of a cross term
    localparam int LW = D + L + 1;      // u times low split
    localparam int SH = PW + 2;         // sum of three high partials
    localparam int SL = LW + 2;         // sum of three low partials
    localparam int W  = 3 * D + 4;      // full determinant

    logic [5:0][PW-1:0]  prod_reg;
    logic [5:0][PW-1:0]  prod_next;
    logic [2:0][D-1:0]   u2_reg;
    logic [2:0][CW-1:0]  cr_reg;
    logic [2:0][CW-1:0]  cr_next;
    logic [2:0][D-1:0]   u3_reg;
    logic [2:0][PW-1:0]  ph_reg;
    logic [2:0][PW-1:0]  ph_next;
    logic [2:0][LW-1:0]  pl_reg;
    logic [2:0][LW-1:0]  pl_next;
    logic [SH-1:0]       shi_reg;
    logic [SH-1:0]       shi_next;
    logic [SL-1:0]       slo_reg;
    logic [SL-1:0]       slo_next;
    logic signed [W-1:0] det;
    ptc_pkg::sign_t      sgn_next;

    always_comb
    begin
        prod_next[0] = PW'($signed(v[1]) * $signed(w[2]));
        prod_next[1] = PW'($signed(v[2]) * $signed(w[1]));
        prod_next[2] = PW'($signed(v[2]) * $signed(w[0]));
        prod_next[3] = PW'($signed(v[0]) * $signed(w[2]));
        prod_next[4] = PW'($signed(v[0]) * $signed(w[1]));
        prod_next[5] = PW'($signed(v[1]) * $signed(w[0]));
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            cr_next[k] = {prod_reg[2*k][PW-1], prod_reg[2*k]}
                       - {prod_reg[2*k+1][PW-1], prod_reg[2*k+1]};
        end
    end

    // split each cross term so both multiplies stay near D x D bits
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pl_next[k] = LW'($signed(u3_reg[k]) * $signed({1'b0, cr_reg[k][L-1:0]}));
            ph_next[k] = PW'($signed(u3_reg[k]) * $signed(cr_reg[k][CW-1:L]));
        end
    end

    always_comb
    begin
        shi_next = {{2{ph_reg[0][PW-1]}}, ph_reg[0]}
                 + {{2{ph_reg[1][PW-1]}}, ph_reg[1]}
                 + {{2{ph_reg[2][PW-1]}}, ph_reg[2]};
        slo_next = {{2{pl_reg[0][LW-1]}}, pl_reg[0]}
                 + {{2{pl_reg[1][LW-1]}}, pl_reg[1]}
                 + {{2{pl_reg[2][LW-1]}}, pl_reg[2]};
    end

    always_comb
    begin
        det = $signed({{(W-SH){shi_reg[SH-1]}}, shi_reg} << L)
            + $signed({{(W-SL){slo_reg[SL-1]}}, slo_reg});
        sgn_next.neg  = det[W-1];
        sgn_next.zero = (det == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            u2_reg   <= u;
            cr_reg   <= cr_next;
            u3_reg   <= u2_reg;
            ph_reg   <= ph_next;
            pl_reg   <= pl_next;
            shi_reg  <= shi_next;
            slo_reg  <= slo_next;
            sgn_reg  <= sgn_next;
        end
    end

endmodule

FILE: rtl/ptc_classify.sv
// Output stage: decide the containing element and hold the result transfer.
module ptc_classify (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  ptc_pkg::hit_t       hit,
    input  ptc_pkg::sign_t [3:0] sg,
    output logic                tvalid_reg,
    output logic [2:0]          kind_reg,
    output logic [1:0]          a_reg,
    output logic [1:0]          b_reg,
    output logic [1:0]          c_reg
);

    logic [3:0] neg;
    logic [3:0] zero;
    logic [1:0] zface;
    logic [2:0] kind_next;
    logic [1:0] a_next;
    logic [1:0] b_next;
    logic [1:0] c_next;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            neg[i]  = sg[i].neg;
            zero[i] = sg[i].zero;
        end
    end

    always_comb
    begin
        zface = 2'd0;
        for (int i = 3; i >= 0; i--)
        begin
            if (zero[i])
            begin
                zface = 2'(i);
            end
        end
    end

    always_comb
    begin
        kind_next = ptc_pkg::KIND_OUTSIDE;
        a_next    = 2'd0;
        b_next    = 2'd0;
        c_next    = 2'd0;
        if (hit.hit)
        begin
            kind_next = ptc_pkg::KIND_VERTEX;
            a_next    = hit.idx;
        end
        else if (neg == 4'b0000)
        begin
            unique case (zero) inside
                4'b0000: kind_next = ptc_pkg::KIND_CELL;
                4'b0001, 4'b0010, 4'b0100, 4'b1000:
                begin
                    kind_next = ptc_pkg::KIND_FACE;
                    a_next    = ptc_pkg::face_vtx(zface, 2'd0);
                    b_next    = ptc_pkg::face_vtx(zface, 2'd1);
                    c_next    = ptc_pkg::face_vtx(zface, 2'd2);
                end
                4'b0011:
                begin
                    kind_next = ptc_pkg::KIND_EDGE;
                    a_next    = 2'd0;
                    b_next    = 2'd2;
                end
                4'b0101:
                begin
                    kind_next = ptc_pkg::KIND_EDGE;
                    a_next    = 2'd0;
                    b_next    = 2'd1;
                end
                4'b1001:
                begin
                    kind_next = ptc_pkg::KIND_EDGE;
                    a_next    = 2'd1;
                    b_next    = 2'd2;
                end
                4'b0110:
                begin
                    kind_next = ptc_pkg::KIND_EDGE;
                    a_next    = 2'd0;
                    b_next    = 2'd3;
                end
                4'b1010:
                begin
                    kind_next = ptc_pkg::KIND_EDGE;
                    a_next    = 2'd2;
                    b_next    = 2'd3;
                end
                4'b1100:
                begin
                    kind_next = ptc_pkg::KIND_EDGE;
                    a_next    = 2'd1;
                    b_next    = 2'd3;
                end
                // three or four zero faces: degenerate, report outside
                default: kind_next = ptc_pkg::KIND_OUTSIDE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            tvalid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind_reg <= kind_next;
            a_reg    <= a_next;
            b_reg    <= b_next;
            c_reg    <= c_next;
        end
    end

`ifndef ASSERT_OFF
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        tvalid_reg |-> (kind_reg <= ptc_pkg::KIND_CELL))
        else $error("element kind out of range");

    a_vertex_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (tvalid_reg && (kind_reg == ptc_pkg::KIND_VERTEX || kind_reg == ptc_pkg::KIND_OUTSIDE
                        || kind_reg == ptc_pkg::KIND_CELL))
        |-> (b_reg == 2'd0 && c_reg == 2'd0))
        else $error("unused vertex slots not cleared");

    a_face_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (tvalid_reg && kind_reg == ptc_pkg::KIND_FACE)
        |-> (a_reg != b_reg && b_reg != c_reg && a_reg != c_reg))
        else $error("face with repeated vertex");
`endif

endmodule

FILE: rtl/point_in_tetrahedron_classify_unit.sv
// Top level of the point-in-tetrahedron classifier.
// Locates one query point against a tetrahedron per transfer: the result is the
// corner it coincides with, the edge, face or cell that holds it, or outside.
// Face signs are exact (full-precision 3x3 determinants). One item enters every
// cycle while the pipeline is not held; the result passes through the
// input register, the five-stage multiply/accumulate chain of each face
// determinant and the output register. The whole pipeline advances together
// and holds while a result waits on m_tready.
module point_in_tetrahedron_classify_unit #(
    parameter int COORD_BITS = ptc_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // corner_zero, corner_one, corner_two, corner_three, query_point (60 bits each), pad
    input  logic [ptc_pkg::IN_DATA_BITS-1:0]  s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // element_kind[2:0], local_a[4:3], local_b[6:5], local_c[8:7], pad
    output logic [ptc_pkg::OUT_DATA_BITS-1:0] m_tdata
);

    localparam int D     = COORD_BITS + 1;
    localparam int DEPTH = 6;

    logic                                              en;
    logic [ptc_pkg::IN_FIELDS-1:0][ptc_pkg::FIELD_BITS-1:0] pts;
    logic [3:0][2:0][D-1:0]                            u;
    logic [3:0][2:0][D-1:0]                            v;
    logic [3:0][2:0][D-1:0]                            w;
    ptc_pkg::hit_t                                     hit;
    ptc_pkg::hit_t [DEPTH-2:0]                         hit_d_reg;
    ptc_pkg::sign_t [3:0]                              sg;
    logic [DEPTH-1:0]                                  vld_reg;
    logic [2:0]                                        kind;
    logic [1:0]                                        la;
    logic [1:0]                                        lb;
    logic [1:0]                                        lc;

    // advance when the output slot is free or its transfer completes now
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_comb
    begin
        for (int p = 0; p < ptc_pkg::IN_FIELDS; p++)
        begin
            pts[p] = s_tdata[p*ptc_pkg::FIELD_BITS +: ptc_pkg::FIELD_BITS];
        end
    end

    ptc_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk     (clk),
        .en      (en),
        .pts     (pts),
        .u_reg   (u),
        .v_reg   (v),
        .w_reg   (w),
        .hit_reg (hit)
    );

    for (genvar f = 0; f < 4; f++)
    begin : g_face
        ptc_orient #(.COORD_BITS(COORD_BITS)) u_orient (
            .clk     (clk),
            .en      (en),
            .u       (u[f]),
            .v       (v[f]),
            .w       (w[f]),
            .sgn_reg (sg[f])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_tvalid};
        end
    end

    // carry the corner match alongside the determinant stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_d_reg <= {hit_d_reg[DEPTH-3:0], hit};
        end
    end

    ptc_classify u_classify (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (vld_reg[DEPTH-1]),
        .hit        (hit_d_reg[DEPTH-2]),
        .sg         (sg),
        .tvalid_reg (m_tvalid),
        .kind_reg   (kind),
        .a_reg      (la),
        .b_reg      (lb),
        .c_reg      (lc)
    );

    assign m_tdata = {7'd0, lc, lb, la, kind};

`ifndef ASSERT_OFF
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted transfer not captured");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(vld_reg) && $stable(m_tvalid)))
        else $error("pipeline moved during output stall");

    a_drain_output: assert property (@(posedge clk) disable iff (!rst_n)
        (en && vld_reg[DEPTH-1]) |=> m_tvalid)
        else $error("finished item lost before output");
`endif

endmodule
